/* rtl/core/nlu_pkg.sv */
// Shared types, constants and helper functions for the normalized Legendre unit.
// Depends on nothing; every other file of the block but nlu_ram imports it.
package nlu_pkg;

  localparam int XW      = 32;   // sine input width
  localparam int PW      = 40;   // stored P value width
  localparam int DPW     = 48;   // derivative width
  localparam int CW      = 32;   // coefficient width
  localparam int MUL_AW  = 63;   // multiplier magnitude operand A
  localparam int MUL_BW  = 40;   // multiplier magnitude operand B
  localparam int MUL_DIG = 8;    // bits of B consumed per cycle
  localparam int PROD_W  = MUL_AW + MUL_BW;
  localparam int RD_OPW  = 62;   // root/divide operand width
  localparam int RD_RESW = 58;   // root/divide result width
  localparam int UW      = 31;   // cosine width
  localparam int MTANW   = 62;   // m times tangent magnitude

  localparam logic signed [PW-1:0] ONE_Q28 = 40'sd268435456;

  typedef enum logic [2:0] {
    BANK_A, BANK_B, BANK_D, BANK_E, BANK_F
  } coef_bank_t;

  typedef enum logic {
    RD_ROOT, RD_DIV
  } rd_mode_t;

  typedef struct packed {
    logic     start;
    rd_mode_t mode;
  } rd_req_t;

  typedef enum logic [1:0] {
    PH_ADDR, PH_GO, PH_WAIT
  } phase_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SQ, S_ROOT, S_DIV, S_INIT, S_DSEL,
    S_MD1, S_MD2, S_ME1, S_ME2,
    S_CSEL, S_CR1, S_CR2, S_MA1, S_MA2, S_MB,
    S_RR, S_RN, S_T1, S_T2, S_OUT
  } state_t;

  // Triangular index of entry (n,m).
  function automatic logic [7:0] tix(input logic [3:0] n, input logic [3:0] m);
    logic [7:0] nn;
    logic [15:0] pr;
    nn = {4'd0, n};
    pr = nn * (nn + 8'd1);
    return pr[8:1] + {4'd0, m};
  endfunction

  // floor(sqrt(num/den) * 2^28), evaluated at elaboration only.
  function automatic logic [CW-1:0] coef_calc(input logic [63:0] num,
                                              input logic [63:0] den);
    logic [127:0] lhs;
    logic [127:0] rhs;
    logic [63:0]  c;
    logic [63:0]  t;
    c   = '0;
    rhs = {64'd0, num} << 56;
    for (int b = 31; b >= 0; b--) begin
      t   = c | (64'd1 << b);
      lhs = {64'd0, t * t} * {64'd0, den};
      if (lhs <= rhs) c = t;
    end
    return c[CW-1:0];
  endfunction

  function automatic logic signed [PW-1:0] sat40(input logic signed [64:0] v);
    if (v > 65'sd549755813887) return 40'sh7FFFFFFFFF;
    else if (v < -65'sd549755813888) return 40'sh8000000000;
    else return $signed(v[PW-1:0]);
  endfunction

  function automatic logic signed [DPW-1:0] sat48(input logic signed [64:0] v);
    if (v > 65'sd140737488355327) return 48'sh7FFFFFFFFFFF;
    else if (v < -65'sd140737488355328) return 48'sh800000000000;
    else return $signed(v[DPW-1:0]);
  endfunction

  function automatic logic [MUL_BW-1:0] mag40(input logic signed [PW-1:0] v);
    return v[PW-1] ? MUL_BW'(-v) : MUL_BW'(v);
  endfunction

endpackage

/* rtl/core/normalized_legendre_unit.sv */
// Normalized Legendre unit: per sine beat, fully normalized P(n,m) and dP/dlat.
// Steps: the square, square root and division, then products on the shared multiplier;
// degree eight needs 197 more products. One input beat is taken only when idle.
// Reset: synchronous active-low rst_n; degree_in_use returns to 8.
// Depends on nlu_pkg, nlu_ram, nlu_coef_rom, nlu_mul, nlu_rootdiv.
module normalized_legendre_unit
  import nlu_pkg::*;
#(
  parameter int MAX_DEGREE = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: degree_in_use.
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  // Input beats. tdata: x_sine[31:0].
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,
  // Result beats. tdata: degree[3:0], order[7:4], value_p[47:8], value_dp[95:48].
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,
  // tuser: derivative_invalid.
  output logic        out_tuser,
  output logic        out_tlast
);

  localparam int TSIZE = (MAX_DEGREE + 1) * (MAX_DEGREE + 2) / 2;
  localparam int AW    = $clog2(TSIZE);

  // Control state.
  state_t state_r, state_nxt;
  phase_t ph_r, ph_nxt;
  logic [3:0] cfg_deg_r;
  logic [3:0] nlim_r;
  logic [3:0] n_r;
  logic [3:0] m_r;

  // Per-item payload.
  logic signed [XW-1:0]  x_r;
  logic                  inv_r;
  logic [60:0]           v_r;
  logic [UW-1:0]         u_r;
  logic [RD_RESW-1:0]    tan_mag_r;
  logic [MTANW-1:0]      mtan_r;
  logic signed [PW-1:0]  diag_r, pa_r, pb_r, cur_r, nxt_r;
  logic signed [63:0]    t_r, p1_r, p2_r;

  // Output register.
  logic                  out_valid_r;
  logic [3:0]            out_deg_r, out_ord_r;
  logic signed [PW-1:0]  out_p_r;
  logic signed [DPW-1:0] out_dp_r;
  logic                  out_inv_r, out_last_r;

  // Shared units.
  logic                  mul_start, mul_done;
  logic [MUL_AW-1:0]     mul_a;
  logic [MUL_BW-1:0]     mul_b;
  logic [PROD_W-1:0]     mul_prod;
  logic                  mul_neg, mul_sh30, mul_state;
  rd_req_t               rd_req;
  logic [RD_OPW-1:0]     rd_opnd;
  logic [RD_RESW-1:0]    rd_res;
  logic                  rd_done;
  coef_bank_t            rom_bank;
  logic [AW-1:0]         rom_idx;
  logic [CW-1:0]         rom_q;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [PW-1:0]         ram_wdata, ram_rdata;

  logic                  in_fire, out_fire, mv;
  logic [31:0]           ux;
  logic [MUL_AW-1:0]     t_abs;
  logic [PROD_W-1:0]     shp;
  logic [MUL_AW-1:0]     fmag;
  logic signed [63:0]    fres;
  logic signed [PW-1:0]  newp;
  logic signed [DPW-1:0] dp;
  logic [7:0]            tix_nm, tix_mm, tix_m1m, tix_n0, tix_nm1;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = (state_r == S_OUT) && (!out_valid_r || out_tready);
  assign mv        = mul_done && (ph_r == PH_WAIT);

  assign ux    = x_r[XW-1] ? 32'(-x_r) : 32'(x_r);
  assign t_abs = t_r[63] ? MUL_AW'(-t_r) : t_r[MUL_AW-1:0];

  assign tix_nm  = tix(n_r, m_r);
  assign tix_mm  = tix(m_r, m_r);
  assign tix_m1m = tix(m_r + 4'd1, m_r);
  assign tix_n0  = tix(n_r, 4'd0);
  assign tix_nm1 = tix(n_r, m_r + 4'd1);

  // Product post-processing: truncate toward zero, clamp magnitude to 2^62, sign.
  always_comb begin
    shp  = mul_sh30 ? (mul_prod >> 30) : (mul_prod >> 28);
    fmag = (shp > (PROD_W'(1) << 62)) ? (MUL_AW'(1) << 62) : shp[MUL_AW-1:0];
    fres = mul_neg ? -$signed({1'b0, fmag}) : $signed({1'b0, fmag});
  end

  assign newp = sat40({p1_r[63], p1_r} - {fres[63], fres});
  assign dp   = inv_r ? '0 : sat48({p1_r[63], p1_r} - {p2_r[63], p2_r});

  // Operand selection for the multiplier and ROM/RAM addresses.
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    mul_neg   = 1'b0;
    mul_sh30  = 1'b0;
    mul_state = 1'b0;
    rom_bank  = BANK_A;
    rom_idx   = tix_nm[AW-1:0];
    ram_raddr = tix_nm[AW-1:0];
    unique case (state_r)
      S_SQ: begin
        mul_state = 1'b1;
        mul_a     = MUL_AW'(ux);
        mul_b     = MUL_BW'(ux);
      end
      S_MD1: begin
        mul_state = 1'b1;
        rom_bank  = BANK_D;
        rom_idx   = AW'(m_r);
        mul_a     = MUL_AW'(rom_q);
        mul_b     = MUL_BW'(u_r);
        mul_sh30  = 1'b1;
      end
      S_MD2, S_ME2: begin
        mul_state = 1'b1;
        mul_a     = t_abs;
        mul_b     = mag40(diag_r);
        mul_neg   = t_r[63] ^ diag_r[PW-1];
      end
      S_ME1: begin
        mul_state = 1'b1;
        rom_bank  = BANK_E;
        rom_idx   = AW'(m_r);
        mul_a     = MUL_AW'(rom_q);
        mul_b     = MUL_BW'(ux);
        mul_neg   = x_r[XW-1];
        mul_sh30  = 1'b1;
      end
      S_MA1: begin
        mul_state = 1'b1;
        rom_bank  = BANK_A;
        mul_a     = MUL_AW'(rom_q);
        mul_b     = MUL_BW'(ux);
        mul_neg   = x_r[XW-1];
        mul_sh30  = 1'b1;
      end
      S_MA2: begin
        mul_state = 1'b1;
        mul_a     = t_abs;
        mul_b     = mag40(pa_r);
        mul_neg   = t_r[63] ^ pa_r[PW-1];
      end
      S_MB: begin
        mul_state = 1'b1;
        rom_bank  = BANK_B;
        mul_a     = MUL_AW'(rom_q);
        mul_b     = mag40(pb_r);
        mul_neg   = pb_r[PW-1];
      end
      S_T1: begin
        mul_state = 1'b1;
        mul_a     = MUL_AW'(mtan_r);
        mul_b     = mag40(cur_r);
        mul_neg   = x_r[XW-1] ^ cur_r[PW-1];
      end
      S_T2: begin
        mul_state = 1'b1;
        rom_bank  = BANK_F;
        mul_a     = MUL_AW'(rom_q);
        mul_b     = mag40(nxt_r);
        mul_neg   = nxt_r[PW-1];
      end
      S_CR1:   ram_raddr = tix_mm[AW-1:0];
      S_CR2:   ram_raddr = tix_m1m[AW-1:0];
      S_RR:    ram_raddr = tix_n0[AW-1:0];
      S_RN:    ram_raddr = tix_nm1[AW-1:0];
      default: ;
    endcase
  end

  assign mul_start = mul_state && (ph_r == PH_GO);

  // Square root runs unless the square of the sine is one or more; division follows it.
  always_comb begin
    rd_req.start = (ph_r == PH_ADDR) &&
                   (((state_r == S_ROOT) && !inv_r) || (state_r == S_DIV));
    rd_req.mode  = (state_r == S_ROOT) ? RD_ROOT : RD_DIV;
    rd_opnd      = (state_r == S_ROOT) ? RD_OPW'(v_r) : {ux[29:0], 32'd0};
  end

  // Table writes: P(0,0), diagonal, subdiagonal and column results.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tix_nm[AW-1:0];
    ram_wdata = newp;
    unique case (state_r)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = ONE_Q28;
      end
      S_MD2: begin
        ram_we    = mv;
        ram_waddr = tix_mm[AW-1:0];
        ram_wdata = sat40(-{fres[63], fres});
      end
      S_ME2: begin
        ram_we    = mv;
        ram_waddr = tix_m1m[AW-1:0];
        ram_wdata = sat40({fres[63], fres});
      end
      S_MB:    ram_we = mv;
      default: ;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    if (mul_state) begin
      unique case (ph_r)
        PH_ADDR: ph_nxt = PH_GO;
        PH_GO:   ph_nxt = PH_WAIT;
        PH_WAIT: if (mul_done) ph_nxt = PH_ADDR;
        default: ph_nxt = PH_ADDR;
      endcase
    end
    unique case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_SQ;
      S_SQ:   if (mv) state_nxt = S_ROOT;
      S_ROOT, S_DIV: begin
        if (ph_r == PH_ADDR) begin
          if ((state_r == S_ROOT) && inv_r) state_nxt = S_INIT;
          else ph_nxt = PH_WAIT;
        end else if (rd_done) begin
          ph_nxt    = PH_ADDR;
          state_nxt = (state_r == S_ROOT) ? S_DIV : S_INIT;
        end
      end
      S_INIT: state_nxt = S_DSEL;
      S_DSEL: begin
        if (m_r > nlim_r) state_nxt = S_CSEL;
        else if (m_r != 4'd0) state_nxt = S_MD1;
        else if (m_r < nlim_r) state_nxt = S_ME1;
      end
      S_MD1: if (mv) state_nxt = S_MD2;
      S_MD2: if (mv) state_nxt = (m_r < nlim_r) ? S_ME1 : S_DSEL;
      S_ME1: if (mv) state_nxt = S_ME2;
      S_ME2: if (mv) state_nxt = S_DSEL;
      S_CSEL: begin
        if (({1'b0, m_r} + 5'd2) > {1'b0, nlim_r}) state_nxt = S_RR;
        else state_nxt = S_CR1;
      end
      S_CR1, S_CR2, S_RR, S_RN: begin
        if (ph_r == PH_ADDR) begin
          ph_nxt = PH_GO;
        end else begin
          ph_nxt = PH_ADDR;
          unique case (state_r)
            S_CR1:   state_nxt = S_CR2;
            S_CR2:   state_nxt = S_MA1;
            S_RR:    state_nxt = (m_r < n_r) ? S_RN : S_T1;
            default: state_nxt = S_T1;
          endcase
        end
      end
      S_MA1: if (mv) state_nxt = S_MA2;
      S_MA2: if (mv) state_nxt = S_MB;
      S_MB:  if (mv) state_nxt = (n_r == nlim_r) ? S_CSEL : S_MA1;
      S_T1:  if (mv) state_nxt = (m_r < n_r) ? S_T2 : S_OUT;
      S_T2:  if (mv) state_nxt = S_OUT;
      S_OUT: begin
        if (out_fire) begin
          if (m_r == n_r) state_nxt = (n_r == nlim_r) ? S_IDLE : S_RR;
          else state_nxt = ((m_r + 4'd1) < n_r) ? S_RN : S_T1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ph_r      <= PH_ADDR;
      cfg_deg_r <= 4'd8;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      if (cfg_we) cfg_deg_r <= cfg_wdata;
    end
  end

  // Loop counters and recursion registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= '0;
      m_r <= '0;
    end else begin
      unique case (state_r)
        S_INIT: m_r <= '0;
        S_DSEL: begin
          if (m_r > nlim_r) m_r <= '0;
          else if ((m_r == 4'd0) && !(m_r < nlim_r)) m_r <= m_r + 4'd1;
        end
        S_MD2: if (mv && !(m_r < nlim_r)) m_r <= m_r + 4'd1;
        S_ME2: if (mv) m_r <= m_r + 4'd1;
        S_CSEL: begin
          if (({1'b0, m_r} + 5'd2) > {1'b0, nlim_r}) begin
            m_r <= '0;
            n_r <= '0;
          end
        end
        S_CR2: if (ph_r == PH_GO) n_r <= m_r + 4'd2;
        S_MB: begin
          if (mv) begin
            if (n_r == nlim_r) m_r <= m_r + 4'd1;
            else n_r <= n_r + 4'd1;
          end
        end
        S_OUT: begin
          if (out_fire) begin
            if (m_r == n_r) begin
              n_r <= n_r + 4'd1;
              m_r <= '0;
            end else begin
              m_r <= m_r + 4'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          x_r    <= $signed(in_tdata);
          nlim_r <= (cfg_deg_r > 4'(MAX_DEGREE)) ? 4'(MAX_DEGREE) : cfg_deg_r;
        end
      end
      S_SQ: begin
        if (mv) begin
          inv_r     <= |mul_prod[PROD_W-1:60];
          v_r       <= (61'd1 << 60) - mul_prod[60:0];
          u_r       <= '0;
          tan_mag_r <= '0;
        end
      end
      S_ROOT:  if (rd_done) u_r <= rd_res[UW-1:0];
      S_DIV:   if (rd_done) tan_mag_r <= rd_res;
      S_INIT:  diag_r <= ONE_Q28;
      S_MD1, S_ME1, S_MA1: if (mv) t_r <= fres;
      S_MD2:   if (mv) diag_r <= sat40(-{fres[63], fres});
      S_CR1:   if (ph_r == PH_GO) pb_r <= $signed(ram_rdata);
      S_CR2:   if (ph_r == PH_GO) pa_r <= $signed(ram_rdata);
      S_MA2:   if (mv) p1_r <= fres;
      S_MB: begin
        if (mv) begin
          pb_r <= pa_r;
          pa_r <= newp;
        end
      end
      S_RR: begin
        if (ph_r == PH_GO) begin
          cur_r  <= $signed(ram_rdata);
          mtan_r <= '0;
        end
      end
      S_RN: if (ph_r == PH_GO) nxt_r <= $signed(ram_rdata);
      S_T1: begin
        if (mv) begin
          p1_r <= fres;
          p2_r <= '0;
        end
      end
      S_T2: if (mv) p2_r <= fres;
      S_OUT: begin
        if (out_fire && (m_r != n_r)) begin
          cur_r  <= nxt_r;
          mtan_r <= mtan_r + MTANW'(tan_mag_r);
        end
      end
      default: ;
    endcase
  end

  // Output register: the next result is computed while this beat waits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      out_deg_r  <= n_r;
      out_ord_r  <= m_r;
      out_p_r    <= cur_r;
      out_dp_r   <= dp;
      out_inv_r  <= inv_r;
      out_last_r <= (m_r == n_r) && (n_r == nlim_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_dp_r, out_p_r, out_ord_r, out_deg_r};
  assign out_tuser  = out_inv_r;
  assign out_tlast  = out_last_r;

  nlu_ram #(
    .WIDTH(PW),
    .DEPTH(TSIZE)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  nlu_coef_rom #(
    .MAX_DEGREE(MAX_DEGREE)
  ) u_rom (
    .clk  (clk),
    .bank (rom_bank),
    .idx  (rom_idx),
    .q    (rom_q)
  );

  nlu_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_prod),
    .done  (mul_done)
  );

  nlu_rootdiv u_rootdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rd_req),
    .opnd  (rd_opnd),
    .den   (u_r),
    .res   (rd_res),
    .done  (rd_done)
  );

  // Table writes always land inside the triangle.
  a_waddr: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (ram_waddr < AW'(TSIZE)))
    else $error("table write outside triangle");

  // Order never exceeds degree on a result beat.
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_ord_r <= out_deg_r))
    else $error("order above degree");

  // The final beat of a run is the diagonal entry.
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_ord_r == out_deg_r))
    else $error("last beat off the diagonal");

  // An undefined derivative is reported as zero.
  a_inv: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_inv_r) |-> (out_dp_r == '0))
    else $error("invalid derivative not zero");

  // The multiplier is started only from a go phase, which is followed by a wait phase with done still low.
  a_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mul_start |=> (ph_r == PH_WAIT) && !mul_done)
    else $error("multiplier sequencing slip");

endmodule

/* rtl/core/nlu_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module nlu_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 45,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/nlu_coef_rom.sv */
// Recursion coefficient ROM: banks A, B, D, E, F built at elaboration.
// Depends on nlu_pkg for the bank type and the coefficient function.
module nlu_coef_rom
  import nlu_pkg::*;
#(
  parameter int MAX_DEGREE = 8,
  localparam int TSIZE = (MAX_DEGREE + 1) * (MAX_DEGREE + 2) / 2,
  localparam int AW = $clog2(TSIZE)
) (
  input  logic          clk,
  input  coef_bank_t    bank,
  input  logic [AW-1:0] idx,
  output logic [CW-1:0] q
);

  logic [CW-1:0] rom_a [TSIZE];
  logic [CW-1:0] rom_b [TSIZE];
  logic [CW-1:0] rom_d [TSIZE];
  logic [CW-1:0] rom_e [TSIZE];
  logic [CW-1:0] rom_f [TSIZE];
  logic [CW-1:0] q_r;

  for (genvar gn = 0; gn <= MAX_DEGREE; gn++) begin : g_n
    for (genvar gm = 0; gm <= gn; gm++) begin : g_m
      localparam int J = gn * (gn + 1) / 2 + gm;
      localparam logic [CW-1:0] CA = (gn >= 2 && gm <= gn - 2) ?
        coef_calc(64'((2 * gn + 1) * (2 * gn - 1)), 64'((gn - gm) * (gn + gm))) : '0;
      localparam logic [CW-1:0] CB = (gn >= 2 && gm <= gn - 2) ?
        coef_calc(64'((2 * gn + 1) * (gn + gm - 1) * (gn - gm - 1)),
                  64'((2 * gn - 3) * (gn - gm) * (gn + gm))) : '0;
      localparam logic [CW-1:0] CF = (gm < gn) ?
        coef_calc(64'((gn - gm) * (gn + gm + 1)), 64'd1) : '0;
      assign rom_a[J] = CA;
      assign rom_b[J] = CB;
      assign rom_f[J] = CF;
    end
  end

  // D and E are indexed by order alone.
  for (genvar gj = 0; gj < TSIZE; gj++) begin : g_j
    localparam logic [CW-1:0] CD = (gj >= 1 && gj <= MAX_DEGREE) ?
      coef_calc(64'(2 * gj + 1), 64'(2 * gj)) : '0;
    localparam logic [CW-1:0] CE = (gj <= MAX_DEGREE - 1) ?
      coef_calc(64'(2 * gj + 3), 64'd1) : '0;
    assign rom_d[gj] = CD;
    assign rom_e[gj] = CE;
  end

  always_ff @(posedge clk) begin
    unique case (bank)
      BANK_A:  q_r <= rom_a[idx];
      BANK_B:  q_r <= rom_b[idx];
      BANK_D:  q_r <= rom_d[idx];
      BANK_E:  q_r <= rom_e[idx];
      BANK_F:  q_r <= rom_f[idx];
      default: q_r <= '0;
    endcase
  end

  assign q = q_r;

endmodule

/* rtl/core/nlu_mul.sv */
// Sequential magnitude multiplier, eight bits of operand B per cycle.
// Depends on nlu_pkg for operand widths.
module nlu_mul
  import nlu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MUL_AW-1:0] a,
  input  logic [MUL_BW-1:0] b,
  output logic [PROD_W-1:0] prod,
  output logic              done
);

  localparam int NDIG = MUL_BW / MUL_DIG;
  localparam int CNTW = $clog2(NDIG + 1);

  logic [MUL_AW-1:0] a_r;
  logic [MUL_BW-1:0] b_r;
  logic [PROD_W-1:0] acc_r;
  logic [CNTW-1:0]   cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [MUL_AW+MUL_DIG-1:0] part;

  assign part = a_r * b_r[MUL_BW-1 -: MUL_DIG];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(NDIG);
      end else if (busy_r) begin
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= (acc_r << MUL_DIG) + PROD_W'(part);
      b_r   <= b_r << MUL_DIG;
    end
  end

  assign prod = acc_r;
  assign done = done_r;

endmodule

/* rtl/core/nlu_rootdiv.sv */
// Shared compare-subtract unit: bit-pair square root or restoring division.
// Depends on nlu_pkg for the request struct and widths.
module nlu_rootdiv
  import nlu_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  rd_req_t            req,
  input  logic [RD_OPW-1:0]  opnd,
  input  logic [UW-1:0]      den,
  output logic [RD_RESW-1:0] res,
  output logic               done
);

  localparam int REMW  = 34;
  localparam int CNTW  = 6;
  localparam int ROOT_STEPS = RD_OPW / 2;
  localparam int DIV_STEPS  = RD_RESW;

  rd_mode_t           mode_r;
  logic [RD_OPW-1:0]  shf_r;
  logic [REMW-1:0]    rem_r;
  logic [RD_RESW-1:0] quo_r;
  logic [UW-1:0]      den_r;
  logic [CNTW-1:0]    cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [REMW-1:0]    rem_sh;
  logic [REMW-1:0]    trial;
  logic               ge;

  always_comb begin
    if (mode_r == RD_ROOT) begin
      rem_sh = {rem_r[REMW-3:0], shf_r[RD_OPW-1 -: 2]};
      trial  = {quo_r[REMW-3:0], 2'b01};
    end else begin
      rem_sh = {rem_r[REMW-2:0], shf_r[RD_OPW-1]};
      trial  = REMW'(den_r);
    end
    ge = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= (req.mode == RD_ROOT) ? CNTW'(ROOT_STEPS) : CNTW'(DIV_STEPS);
      end else if (busy_r) begin
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mode_r <= req.mode;
      shf_r  <= opnd;
      den_r  <= den;
      rem_r  <= '0;
      quo_r  <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? rem_sh - trial : rem_sh;
      quo_r <= {quo_r[RD_RESW-2:0], ge};
      shf_r <= (mode_r == RD_ROOT) ? shf_r << 2 : shf_r << 1;
    end
  end

  assign res  = quo_r;
  assign done = done_r;

endmodule

/* dv/normalized_legendre_unit_test.sv */
// Self-checking testbench for normalized_legendre_unit: drives sine-of-latitude beats,
// predicts every P(n,m) and dP(n,m) beat in fixed point and checks them in order.
// Depends on nlu_pkg and the normalized_legendre_unit RTL.
module normalized_legendre_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import nlu_pkg::*;

  localparam int MAXD = 8;
  localparam int TSZ = (MAXD + 1) * (MAXD + 2) / 2;

  typedef struct packed {
    logic [3:0]  degree;
    logic [3:0]  order;
    logic [39:0] value_p;
    logic [47:0] value_dp;
    logic        invalid;
    logic        last;
  } legendre_beat_t;

  // Holds the coefficient banks, the degree setting and the queue of expected beats.
  class legendre_scoreboard;
    logic [31:0] coef_a[TSZ], coef_b[TSZ], coef_d[TSZ], coef_e[TSZ], coef_f[TSZ];
    int unsigned degree_setting;
    legendre_beat_t pending[$];
    int errors;

    function int tri_ix(int n, int m);
      return n * (n + 1) / 2 + m;
    endfunction

    // floor(sqrt(num/den) * 2^28) by bitwise search.
    function logic [31:0] root_ratio(longint unsigned num, longint unsigned den);
      logic [127:0] c, t;
      c = 0;
      for (int b = 31; b >= 0; b--) begin
        t = c | (128'd1 << b);
        if (t * t * den <= (128'(num) << 56)) c = t;
      end
      return c[31:0];
    endfunction

    function void init();
      degree_setting = 8;
      errors = 0;
      for (int i = 0; i < TSZ; i++) begin
        coef_a[i] = 0; coef_b[i] = 0; coef_d[i] = 0; coef_e[i] = 0; coef_f[i] = 0;
      end
      for (int n = 2; n <= MAXD; n++)
        for (int m = 0; m <= n - 2; m++) begin
          coef_a[tri_ix(n, m)] = root_ratio((2*n+1)*(2*n-1), (n-m)*(n+m));
          coef_b[tri_ix(n, m)] = root_ratio((2*n+1)*(n+m-1)*(n-m-1), (2*n-3)*(n-m)*(n+m));
        end
      for (int m = 1; m <= MAXD; m++) coef_d[m] = root_ratio(2*m+1, 2*m);
      for (int m = 0; m < MAXD; m++) coef_e[m] = root_ratio(2*m+3, 1);
      for (int m = 0; m <= MAXD; m++)
        for (int n = m + 1; n <= MAXD; n++)
          coef_f[tri_ix(n, m)] = root_ratio((n-m)*(n+m+1), 1);
    endfunction

    // Signed product shifted right by sh, truncated toward zero, magnitude capped at 2^62.
    function longint scaled_mul(longint a, longint b, int sh);
      logic [127:0] mag;
      logic neg;
      neg = (a < 0) != (b < 0);
      mag = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
      mag = mag >> sh;
      if (mag > (128'd1 << 62)) mag = 128'd1 << 62;
      return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function longint clamp(longint v, int bits);
      longint mx;
      mx = (longint'(1) << (bits - 1)) - 1;
      if (v > mx) return mx;
      if (v < -mx - 1) return -mx - 1;
      return v;
    endfunction

    function void note_sine(logic [31:0] raw);
      longint x, tn, t, p, dp, t1, t2;
      longint unsigned ux, sq, u, r, tt;
      longint tbl[TSZ];
      bit inv;
      int nmax, k, total;
      legendre_beat_t e;
      x = longint'($signed(raw));
      nmax = degree_setting > MAXD ? MAXD : degree_setting;
      ux = x < 0 ? -x : x;
      sq = ux * ux;
      u = 0;
      if (sq < (64'd1 << 60)) begin
        r = 0;
        for (int b = 30; b >= 0; b--) begin
          tt = r | (64'd1 << b);
          if (tt * tt <= (64'd1 << 60) - sq) r = tt;
        end
        u = r;
      end
      inv = (u == 0);
      tn = 0;
      if (!inv) tn = x < 0 ? -longint'((ux << 28) / u) : longint'((ux << 28) / u);
      for (int i = 0; i < TSZ; i++) tbl[i] = 0;
      tbl[0] = longint'(1) << 28;
      for (int m = 0; m <= nmax; m++) begin
        if (m > 0) begin
          t = scaled_mul(coef_d[m], u, 30);
          p = scaled_mul(t, tbl[tri_ix(m-1, m-1)], 28);
          tbl[tri_ix(m, m)] = clamp(-p, 40);
        end
        if (m < nmax) begin
          t = scaled_mul(x, coef_e[m], 30);
          tbl[tri_ix(m+1, m)] = clamp(scaled_mul(t, tbl[tri_ix(m, m)], 28), 40);
        end
      end
      for (int m = 0; m <= nmax - 2; m++)
        for (int n = m + 2; n <= nmax; n++) begin
          t = scaled_mul(coef_a[tri_ix(n, m)], x, 30);
          t1 = scaled_mul(t, tbl[tri_ix(n-1, m)], 28);
          t2 = scaled_mul(coef_b[tri_ix(n, m)], tbl[tri_ix(n-2, m)], 28);
          tbl[tri_ix(n, m)] = clamp(t1 - t2, 40);
        end
      total = (nmax + 1) * (nmax + 2) / 2;
      k = 0;
      for (int n = 0; n <= nmax; n++)
        for (int m = 0; m <= n; m++) begin
          dp = 0;
          if (!inv) begin
            t1 = scaled_mul(m * tn, tbl[tri_ix(n, m)], 28);
            t2 = (m < n) ? scaled_mul(coef_f[tri_ix(n, m)], tbl[tri_ix(n, m+1)], 28) : 0;
            dp = clamp(t1 - t2, 48);
          end
          e.degree = 4'(n); e.order = 4'(m);
          e.value_p = tbl[tri_ix(n, m)][39:0];
          e.value_dp = dp[47:0];
          e.invalid = inv;
          e.last = (k == total - 1);
          pending.push_back(e);
          k++;
        end
    endfunction

    function void check_beat(legendre_beat_t got);
      legendre_beat_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected beat %h", $realtime, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t: mismatch expected n=%0d m=%0d p=%h dp=%h inv=%b last=%b", $realtime,
                 want.degree, want.order, want.value_p, want.value_dp, want.invalid, want.last);
        $display("%0t:          actual   n=%0d m=%0d p=%h dp=%h inv=%b last=%b", $realtime,
                 got.degree, got.order, got.value_p, got.value_dp, got.invalid, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n, cfg_we, in_tvalid, in_tready, out_tvalid, out_tready, out_tuser, out_tlast;
  logic [3:0] cfg_wdata;
  logic [31:0] in_tdata;
  logic [95:0] out_tdata;

  legendre_scoreboard board;
  int send_idle_pct, recv_stall_pct;
  bit hold_recv;

  normalized_legendre_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Hard limit: far above the slowest correct run of about 260 beats,
  // with the receiver stalling most of the time.
  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

  // Receiver: stalls at the current rate, or holds off entirely while hold_recv is set.
  // Result beats are checked at the rising edge where they are accepted.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_beat('{out_tdata[3:0], out_tdata[7:4], out_tdata[47:8], out_tdata[95:48],
                         out_tuser, out_tlast});
  end

  always @(negedge clk) begin
    out_tready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
  end

  // Offers one sine beat, with random idle cycles in front, and waits for its acceptance.
  // It waits for a falling edge after dropping tvalid before it returns, so the next beat
  // never lands on the same edge.
  task automatic send_sine(logic [31:0] x);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_tvalid <= 1;
    in_tdata <= x;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_sine(x);
    @(negedge clk);
    in_tvalid <= 0;
    @(negedge clk);
  endtask

  // Waits for the queue of expected beats to drain, then lets the core finish its run.
  task automatic drain();
    while (board.pending.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic set_degree(logic [3:0] d);
    drain();
    cfg_we <= 1;
    cfg_wdata <= d;
    board.degree_setting = d;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // Mostly sines in range; a few at or just inside the poles, and some raw 32-bit patterns.
  function automatic logic [31:0] random_sine();
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) return $urandom_range(32'h8000_0000) - 32'h4000_0000;
    if (sel < 80) return $urandom_range(1) ? 32'h4000_0000 - $urandom_range(3)
                                           : 32'hC000_0000 + $urandom_range(3);
    return $urandom;
  endfunction

  initial begin
    logic [31:0] directed[$];
    logic [3:0] degrees[$];
    board = new();
    board.init();
    rst_n = 0; cfg_we = 0; cfg_wdata = 0; in_tvalid = 0; in_tdata = 0;
    hold_recv = 0; send_idle_pct = 0; recv_stall_pct = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed beats: poles, equator, beyond the poles, the widest raw patterns.
    directed = '{32'h0000_0000, 32'h4000_0000, 32'hC000_0000, 32'h3FFF_FFFF, 32'hC000_0001,
                 32'h4000_0001, 32'hBFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                 32'h0000_0001, 32'h2000_0000, 32'hE000_0000, 32'h5555_5555, 32'hAAAA_AAAA};
    foreach (directed[i]) send_sine(directed[i]);
    // Reset degree was 8; now each extreme, and a setting above the maximum.
    degrees = '{4'd0, 4'd15, 4'd1, 4'd9};
    foreach (degrees[i]) begin
      set_degree(degrees[i]);
      send_sine(32'h0000_0000);
      send_sine(32'h2D41_3CCD);
      send_sine(32'h4000_0000);
    end

    // Long receiver hold-off while the sender keeps offering beats.
    set_degree(4'd2);
    fork
      begin
        hold_recv = 1;
        repeat (3000) @(negedge clk);
        hold_recv = 0;
      end
      repeat (6) send_sine(random_sine());
    join
    drain();

    // Random phases: no idling, sender idle, receiver stalls, both.
    for (int ph = 0; ph < 4; ph++) begin
      set_degree(ph == 0 ? 4'd8 : 4'($urandom_range(15)));
      send_idle_pct = (ph == 1) ? 63 : (ph == 3) ? 24 : 0;
      recv_stall_pct = (ph == 2) ? 63 : (ph == 3) ? 24 : 0;
      for (int i = 0; i < 55; i++) begin
        if (i % 10 == 9) set_degree(4'($urandom_range(15)));
        send_sine(random_sine());
      end
    end
    drain();
    repeat (2000) @(negedge clk);

    if (board.errors == 0 && board.pending.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end
endmodule

/* sim.f */
rtl/core/nlu_pkg.sv
rtl/core/nlu_ram.sv
rtl/core/nlu_coef_rom.sv
rtl/core/nlu_mul.sv
rtl/core/nlu_rootdiv.sv
rtl/core/normalized_legendre_unit.sv
dv/normalized_legendre_unit_test.sv
